[hdl/qoi_pkg.sv]
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types, codes and helpers for the QOI-style RGB pixel decoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

	// color cache geometry
	localparam int CACHE_ENTRIES = 64;
	localparam int CACHE_AW      = $clog2(CACHE_ENTRIES);

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// decode phases: tag expected, or literal red, green, blue pending
	localparam logic [1:0] PH_TAG = 2'd0;
	localparam logic [1:0] PH_R   = 2'd1;
	localparam logic [1:0] PH_G   = 2'd2;
	localparam logic [1:0] PH_B   = 2'd3;

	// tag byte codes
	localparam logic [7:0] TAG_RGB  = 8'd254;
	localparam logic [1:0] OP_INDEX = 2'b00;
	localparam logic [1:0] OP_DIFF  = 2'b01;
	localparam logic [1:0] OP_LUMA  = 2'b10;
	localparam logic [1:0] OP_RUN   = 2'b11;

	// diff biases
	localparam logic [7:0] DIFF_BIAS  = 8'd2;
	localparam logic [7:0] LUMA_BIAS  = 8'd32;
	localparam logic [7:0] LUMA_RB    = 8'd40;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// decoder verdict for one byte
	typedef struct packed {
		logic                has_pix;
		logic                is_run;
		logic                cache_we;
		logic                set_prev;
		logic                load_first;
		logic                load_second;
		logic                next_luma;
		logic [1:0]          next_phase;
		rgb_t                pix;
		logic [CACHE_AW-1:0] cache_addr;
	} dec_t;

	// cache slot: (3r + 5g + 7b) mod 64
	function automatic logic [CACHE_AW-1:0] px_hash(rgb_t p);
		return CACHE_AW'(p.r[CACHE_AW-1:0] * CACHE_AW'(3)
			+ p.g[CACHE_AW-1:0] * CACHE_AW'(5)
			+ p.b[CACHE_AW-1:0] * CACHE_AW'(7));
	endfunction

endpackage

[hdl/qoi_style_rgb_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// qoi_style_rgb_pixel_decoder_top
// QOI-style RGB decoder: compressed bytes in, raster-ordered pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one compressed byte per request. m_* gives one pixel per
//   request: tdata holds red, green, blue, column, row; tlast marks the last
//   pixel caused by a byte; tuser marks the last pixel of the image.
//   cfg_we/cfg_addr/cfg_wdata set image width (index 0) and height (index 1)
//   while the decoder is idle.
// Timing:
//   a byte taken sits in the input register, and its pixel is loaded from
//   there into the output register once that register is free. Literal, diff,
//   index and luma bytes are taken at one per cycle while the output is not
//   stalled. A run byte holds the input register until its last pixel is out,
//   one pixel per cycle out of the output register while it is not stalled.
// Reset:
//   previous pixel black, cache reads as black, position at column 0 row 0.
//   After the last pixel of the image all further bytes are taken and
//   dropped until reset.
// Stall:
//   a stalled output holds its pixel; the input register keeps taking bytes
//   until one that makes a pixel waits there, then s_tready stays low until
//   the output moves.
// ----------------------------------------------------------------------------
module qoi_style_rgb_pixel_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
	                               // [39:24] column, [55:40] row
	output logic        m_tlast,   // last_of_item
	output logic        m_tuser,   // [0] image_end
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import qoi_pkg::*;

	logic [15:0]         width_q;
	logic [15:0]         height_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [1:0]          phase_q;
	logic                luma_q;
	logic [7:0]          held_first_q;
	logic [7:0]          held_second_q;
	rgb_t                prev_q;
	logic [5:0]          run_cnt_q;
	logic                valid_s2;
	logic [55:0]         data_s2;
	logic                last_s2;
	logic                end_s2;

	logic                accept;
	logic                adv;
	logic                act;
	logic                emit;
	logic                upd;
	logic                last_run;
	logic                s1_done;
	logic                last_item;
	logic                cache_we;
	rgb_t                cache_px;
	dec_t                dec;
	logic [15:0]         column;
	logic [15:0]         row;
	logic                image_end;
	logic                frame_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd1;
			height_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake and stage control
	assign accept   = s_tvalid && s_tready;
	assign adv      = !valid_s2 || m_tready;
	assign act      = valid_s1 && !frame_done;
	assign emit     = act && dec.has_pix && adv;
	assign upd      = act && (!dec.has_pix || adv);
	assign last_run = (run_cnt_q == byte_s1[5:0]) || image_end;
	assign s1_done  = valid_s1 && (frame_done || !dec.has_pix
		|| (adv && (!dec.is_run || last_run)));
	assign s_tready = !valid_s1 || s1_done;
	assign last_item = !dec.is_run || last_run;
	assign cache_we = emit && dec.cache_we;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
		end
	end

	// color cache, read at acceptance
	qoi_cache u_cache (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (s_tdata[CACHE_AW-1:0]),
		.wr_en   (cache_we),
		.wr_addr (dec.cache_addr),
		.wr_data (dec.pix),
		.rd_data (cache_px)
	);

	// tag decode
	qoi_decode u_decode (
		.byte_in      (byte_s1),
		.phase        (phase_q),
		.luma_pending (luma_q),
		.held_first   (held_first_q),
		.held_second  (held_second_q),
		.prev_px      (prev_q),
		.cache_px     (cache_px),
		.dec          (dec)
	);

	// raster position
	qoi_raster u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (emit),
		.image_width  (width_q),
		.image_height (height_q),
		.column       (column),
		.row          (row),
		.image_end    (image_end),
		.frame_done   (frame_done)
	);

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			luma_q        <= 1'b0;
			held_first_q  <= '0;
			held_second_q <= '0;
			prev_q        <= '0;
		end else if (upd) begin
			phase_q <= dec.next_phase;
			luma_q  <= dec.next_luma;
			if (dec.load_first) begin
				held_first_q <= byte_s1;
			end
			if (dec.load_second) begin
				held_second_q <= byte_s1;
			end
			if (dec.set_prev) begin
				prev_q <= dec.pix;
			end
		end
	end

	// run pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (s1_done) begin
			run_cnt_q <= '0;
		end else if (emit && dec.is_run) begin
			run_cnt_q <= run_cnt_q + 6'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_s2 <= {row, column, dec.pix.b, dec.pix.g, dec.pix.r};
			last_s2 <= last_item;
			end_s2  <= image_end;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = end_s2;

endmodule

[hdl/qoi_cache.sv]
// ----------------------------------------------------------------------------
// qoi_cache
// 64-entry color cache: one write and one registered read per cycle, with
// per-entry valid bits (an unwritten entry reads as black) and forwarding of
// a write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module qoi_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [qoi_pkg::CACHE_AW-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [qoi_pkg::CACHE_AW-1:0] wr_addr,
	input  qoi_pkg::rgb_t                wr_data,
	output qoi_pkg::rgb_t                rd_data
);
	import qoi_pkg::*;

	rgb_t                     mem_q [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;
	rgb_t                     mem_rd_q;
	logic                     rd_valid_q;
	logic                     fwd_hit_q;
	rgb_t                     fwd_data_q;

	// storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem_q[rd_addr];
		end
	end

	// valid bits and forwarding control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// forwarded write data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	// resolved read data
	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_data_q;
		end else if (rd_valid_q) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

[hdl/qoi_decode.sv]
// ----------------------------------------------------------------------------
// qoi_decode
// Combinational tag decode of one stream byte against the current decode
// state: yields the pixel, cache write and next state.
// ----------------------------------------------------------------------------
module qoi_decode (
	input  logic [7:0]    byte_in,
	input  logic [1:0]    phase,
	input  logic          luma_pending,
	input  logic [7:0]    held_first,
	input  logic [7:0]    held_second,
	input  qoi_pkg::rgb_t prev_px,
	input  qoi_pkg::rgb_t cache_px,
	output qoi_pkg::dec_t dec
);
	import qoi_pkg::*;

	logic [7:0] luma_g;

	assign luma_g = {2'b00, held_first[5:0]};

	always_comb begin
		dec            = '0;
		dec.next_phase = phase;
		dec.next_luma  = luma_pending;
		dec.pix        = prev_px;

		if (luma_pending) begin
			// second luma byte completes the pixel
			dec.pix.r       = prev_px.r + luma_g + {4'b0000, byte_in[7:4]} - LUMA_RB;
			dec.pix.g       = prev_px.g + luma_g - LUMA_BIAS;
			dec.pix.b       = prev_px.b + luma_g + {4'b0000, byte_in[3:0]} - LUMA_RB;
			dec.has_pix     = 1'b1;
			dec.cache_we    = 1'b1;
			dec.set_prev    = 1'b1;
			dec.next_luma   = 1'b0;
		end else begin
			case (phase)
				PH_R: begin
					dec.load_first = 1'b1;
					dec.next_phase = PH_G;
				end
				PH_G: begin
					dec.load_second = 1'b1;
					dec.next_phase  = PH_B;
				end
				PH_B: begin
					dec.pix        = '{r: held_first, g: held_second, b: byte_in};
					dec.has_pix    = 1'b1;
					dec.cache_we   = 1'b1;
					dec.set_prev   = 1'b1;
					dec.next_phase = PH_TAG;
				end
				default: begin
					if (byte_in == TAG_RGB) begin
						dec.next_phase = PH_R;
					end else begin
						case (byte_in[7:6])
							OP_RUN: begin
								dec.has_pix = 1'b1;
								dec.is_run  = 1'b1;
							end
							OP_INDEX: begin
								dec.pix      = cache_px;
								dec.has_pix  = 1'b1;
								dec.set_prev = 1'b1;
							end
							OP_DIFF: begin
								dec.pix.r    = prev_px.r + {6'b0, byte_in[5:4]} - DIFF_BIAS;
								dec.pix.g    = prev_px.g + {6'b0, byte_in[3:2]} - DIFF_BIAS;
								dec.pix.b    = prev_px.b + {6'b0, byte_in[1:0]} - DIFF_BIAS;
								dec.has_pix  = 1'b1;
								dec.cache_we = 1'b1;
								dec.set_prev = 1'b1;
							end
							default: begin
								// first luma byte is held
								dec.load_first = 1'b1;
								dec.next_luma  = 1'b1;
							end
						endcase
					end
				end
			endcase
		end

		dec.cache_addr = px_hash(dec.pix);
	end

endmodule

[hdl/qoi_raster.sv]
// ----------------------------------------------------------------------------
// qoi_raster
// Raster position of the next pixel and end-of-image tracking.
// ----------------------------------------------------------------------------
module qoi_raster (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [15:0] image_width,
	input  logic [15:0] image_height,
	output logic [15:0] column,
	output logic [15:0] row,
	output logic        image_end,
	output logic        frame_done
);
	logic [15:0] col_q;
	logic [15:0] row_q;
	logic        done_q;
	logic        col_wrap;
	logic        row_end;

	// wrap tests; a zero register behaves as one
	assign col_wrap  = ({1'b0, col_q} + 17'd1) >= {1'b0, image_width};
	assign row_end   = ({1'b0, row_q} + 17'd1) >= {1'b0, image_height};
	assign image_end = col_wrap && row_end;

	assign column     = col_q;
	assign row        = row_q;
	assign frame_done = done_q;

	// position advance per emitted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (step) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_end) begin
					done_q <= 1'b1;
				end else begin
					row_q <= row_q + 16'd1;
				end
			end else begin
				col_q <= col_q + 16'd1;
			end
		end
	end

endmodule

[hdl/qoi_chk.sv]
// ----------------------------------------------------------------------------
// qoi_chk
// Port-level checks for the QOI-style decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qoi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// a stalled pixel holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output pixel changed while stalled");

	// image end always closes a byte's pixels
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end without last pixel of byte");

	// nothing follows the last pixel of the image
	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser |=> !m_tvalid)
		else $error("pixel after image end");

	// a run continues without a gap once its pixel is taken
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("run pixel missing");

endmodule

bind qoi_style_rgb_pixel_decoder_top qoi_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.m_tuser   (m_tuser)
);

[test/tb_qoi_style_rgb_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_qoi_style_rgb_pixel_decoder_top
// Self-checking bench for the QOI-style RGB pixel decoder.
// ----------------------------------------------------------------------------
// Bytes go in over the input stream. A behavioral decoder in this file tracks
// the previous pixel, the color cache and the raster position, and queues the
// pixels each byte should produce. Every pixel request on the output stream
// is checked against the oldest queued pixel. A short table of hand-picked
// bytes runs first, then random tag sequences under several image
// geometries. The last geometry ends the image, so trailing bytes must be
// dropped. Both stream sides idle at random, and the pixel side once holds
// off for a long stretch so the input side backs up.
// ----------------------------------------------------------------------------
module tb_qoi_style_rgb_pixel_decoder_top;

	import qoi_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 3;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 12;
	localparam int MAX_REPORTS  = 10;
	localparam int IDLE_PCT     = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int SLOTS        = 64;
	localparam int DIFF_OFFSET  = 2;
	localparam int LUMA_G_OFF   = 32;
	localparam int LUMA_RB_OFF  = 8;
	localparam int DIRECTED_N   = 24;

	// one expected pixel as it leaves the decoder
	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [15:0] col;
		logic [15:0] row;
		logic        last;
		logic        iend;
	} pixel_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = REG_IMAGE_WIDTH;
	logic [15:0] cfg_wdata = 16'd0;

	qoi_style_rgb_pixel_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// decoder shadow state
	logic [1:0]  lit_phase;
	bit          luma_wait;
	logic [7:0]  held_r;
	logic [7:0]  held_g;
	logic [7:0]  luma_tag;
	rgb_t        prev_px;
	rgb_t        palette [SLOTS];
	int unsigned width_reg;
	int unsigned height_reg;
	int unsigned col_pos;
	int unsigned row_pos;
	bit          image_done;

	pixel_t      byte_pixels [SLOTS];
	pixel_t      expected_pixels [$];
	pixel_t      want;
	pixel_t      got;

	int          errors       = 0;
	int          bytes_sent   = 0;
	int          pixels_seen  = 0;
	int          runs_sent    = 0;
	int          cycle_count  = 0;
	int          hold_left    = 0;
	bit          hold_done    = 0;

	// directed bytes: {checked by hand, byte, expected r g b}
	logic [32:0] directed [DIRECTED_N] = '{
		{1'b1, OP_INDEX, 6'd0,       24'h000000},  // cache reads black after reset
		{1'b0, TAG_RGB,              24'h000000},
		{1'b0, 8'hFF,                24'h000000},
		{1'b0, 8'hFF,                24'h000000},
		{1'b1, 8'hFF,                24'hFFFFFF},  // literal white
		{1'b1, OP_DIFF, 6'b000000,   24'hFDFDFD},  // diff all -2
		{1'b1, OP_DIFF, 6'b111111,   24'hFEFEFE},  // diff all +1
		{1'b0, OP_DIFF, 6'b101010,   24'h000000},  // diff of zero
		{1'b0, OP_LUMA, 6'd0,        24'h000000},
		{1'b1, 8'h00,                24'hD6DED6},  // most negative luma
		{1'b0, OP_LUMA, 6'd63,       24'h000000},
		{1'b0, 8'hFF,                24'h000000},  // most positive luma
		{1'b0, OP_RUN, 6'd0,         24'h000000},  // shortest run
		{1'b0, TAG_RGB,              24'h000000},
		{1'b0, 8'h00,                24'h000000},
		{1'b0, 8'h00,                24'h000000},
		{1'b1, 8'h00,                24'h000000},  // literal black
		{1'b1, OP_DIFF, 6'b000000,   24'hFEFEFE},  // diff wraps below zero
		{1'b0, OP_RUN, 6'd61,        24'h000000},  // run of 62
		{1'b0, OP_RUN, 6'd63,        24'h000000},  // run of 64
		{1'b1, OP_INDEX, 6'd49,      24'hFFFFFF},  // white still cached
		{1'b1, OP_INDEX, 6'd63,      24'h000000},  // slot never written
		{1'b0, OP_LUMA, 6'd32,       24'h000000},
		{1'b0, 8'h88,                24'h000000}   // luma of zero
	};

	// pixel arithmetic, wrapping per component
	function automatic rgb_t nudge(rgb_t p, int dr, int dg, int db);
		rgb_t q;
		q.r = 8'(int'(p.r) + dr);
		q.g = 8'(int'(p.g) + dg);
		q.b = 8'(int'(p.b) + db);
		return q;
	endfunction

	task automatic remember(input rgb_t p);
		int slot;
		slot = (3 * int'(p.r) + 5 * int'(p.g) + 7 * int'(p.b)) % SLOTS;
		palette[slot] = p;
	endtask

	// record one pixel at the current position and step the raster
	task automatic place(input rgb_t p, inout int n);
		byte_pixels[n] = {p.r, p.g, p.b, col_pos[15:0], row_pos[15:0], 1'b0, 1'b0};
		if (col_pos + 1 >= width_reg) begin
			col_pos = 0;
			if (row_pos + 1 >= height_reg) begin
				image_done = 1;
				byte_pixels[n].iend = 1'b1;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
		n = n + 1;
	endtask

	// pixels caused by one accepted byte
	task automatic decode_byte(input logic [7:0] code, output int n);
		rgb_t px;
		int   dg;
		int   len;
		n = 0;
		if (image_done)
			return;
		if (luma_wait) begin
			luma_wait = 0;
			dg = int'(luma_tag[5:0]) - LUMA_G_OFF;
			px = nudge(prev_px, int'(code[7:4]) - LUMA_RB_OFF + dg, dg,
				int'(code[3:0]) - LUMA_RB_OFF + dg);
			remember(px);
			place(px, n);
			prev_px = px;
		end else if (lit_phase == PH_R) begin
			held_r = code;
			lit_phase = PH_G;
		end else if (lit_phase == PH_G) begin
			held_g = code;
			lit_phase = PH_B;
		end else if (lit_phase == PH_B) begin
			lit_phase = PH_TAG;
			px = '{held_r, held_g, code};
			remember(px);
			place(px, n);
			prev_px = px;
		end else if (code == TAG_RGB) begin
			lit_phase = PH_R;
		end else if (code[7:6] == OP_RUN) begin
			len = int'(code[5:0]) + 1;
			for (int k = 0; k < len && !image_done; k++)
				place(prev_px, n);
		end else if (code[7:6] == OP_INDEX) begin
			px = palette[code[5:0]];
			place(px, n);
			prev_px = px;
		end else if (code[7:6] == OP_DIFF) begin
			px = nudge(prev_px, int'(code[5:4]) - DIFF_OFFSET,
				int'(code[3:2]) - DIFF_OFFSET, int'(code[1:0]) - DIFF_OFFSET);
			remember(px);
			place(px, n);
			prev_px = px;
		end else begin
			luma_tag = code;
			luma_wait = 1;
		end
		if (n > 0)
			byte_pixels[n - 1].last = 1'b1;
	endtask

	// offer one byte, wait for its request to complete, queue its pixels
	task automatic send_byte(input logic [7:0] code, input bit typed, input rgb_t typed_px);
		int n;
		if (!(bytes_sent >= 70 && bytes_sent < 120) && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		bytes_sent++;
		if (!(lit_phase != PH_TAG || luma_wait) && code[7:6] == OP_RUN && code != TAG_RGB)
			runs_sent++;
		decode_byte(code, n);
		if (typed && n > 0) begin
			byte_pixels[0].r = typed_px.r;
			byte_pixels[0].g = typed_px.g;
			byte_pixels[0].b = typed_px.b;
		end
		for (int k = 0; k < n; k++)
			expected_pixels.push_back(byte_pixels[k]);
	endtask

	// random component with extra weight on the extremes
	function automatic logic [7:0] pick_component();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 8'h00;
		else if (pick < 20)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// one well-formed coding with random content, or a stray byte
	task automatic send_random_item();
		int   pick;
		rgb_t none;
		none = '0;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_byte(8'($urandom_range(255)), 0, none);
		end else if (pick < 30) begin
			send_byte({OP_INDEX, 6'($urandom_range(63))}, 0, none);
		end else if (pick < 50) begin
			send_byte({OP_DIFF, 6'($urandom_range(63))}, 0, none);
		end else if (pick < 65) begin
			send_byte({OP_LUMA, 6'($urandom_range(63))}, 0, none);
			send_byte(8'($urandom_range(255)), 0, none);
		end else if (pick < 82) begin
			send_byte(TAG_RGB, 0, none);
			send_byte(pick_component(), 0, none);
			send_byte(pick_component(), 0, none);
			send_byte(pick_component(), 0, none);
		end else if ($urandom_range(9) == 0) begin
			send_byte({OP_RUN, 6'($urandom_range(63))}, 0, none);
		end else begin
			send_byte({OP_RUN, 6'($urandom_range(7))}, 0, none);
		end
	endtask

	// stop offering, let every queued pixel arrive, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write width then height on back-to-back edges
	task automatic set_geometry(input logic [15:0] w, input logic [15:0] h);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_addr  <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
		width_reg  = w;
		height_reg = h;
	endtask

	// pixel side ready: random stalls, one long hold-off, one calm stretch
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && pixels_seen >= 60) begin
			hold_done <= 1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (pixels_seen >= 150 && pixels_seen < 450) begin
			m_tready  <= 1'b1;
		end else begin
			m_tready  <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// check each pixel request against the oldest expectation
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			pixels_seen++;
			got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[39:24],
				m_tdata[55:40], m_tlast, m_tuser};
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected pixel rgb=%h %h %h col=%0d row=%0d last=%b end=%b",
						got.r, got.g, got.b, got.col, got.row, got.last, got.iend);
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("pixel %0d mismatch", pixels_seen);
						$display("  expected rgb=%h %h %h col=%0d row=%0d last=%b end=%b",
							want.r, want.g, want.b, want.col, want.row, want.last, want.iend);
						$display("  actual   rgb=%h %h %h col=%0d row=%0d last=%b end=%b",
							got.r, got.g, got.b, got.col, got.row, got.last, got.iend);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// main sequence
	initial begin
		lit_phase  = PH_TAG;
		luma_wait  = 0;
		held_r     = '0;
		held_g     = '0;
		luma_tag   = '0;
		prev_px    = '0;
		for (int k = 0; k < SLOTS; k++)
			palette[k] = '0;
		width_reg  = 1;
		height_reg = 1;
		col_pos    = 0;
		row_pos    = 0;
		image_done = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// zero width acts as one column, tall image
		set_geometry(16'd0, 16'hFFFF);
		for (int k = 0; k < DIRECTED_N; k++)
			send_byte(directed[k][31:24], directed[k][32], directed[k][23:0]);
		drain();

		// widest and tallest image
		set_geometry(16'hFFFF, 16'hFFFF);
		while (bytes_sent < DIRECTED_N + 50)
			send_random_item();
		drain();

		// narrow rows, column wraps at once from the previous geometry
		set_geometry(16'd7, 16'hFFFF);
		while (bytes_sent < DIRECTED_N + 95)
			send_random_item();
		drain();

		// zero height: the image ends at the end of the current row
		set_geometry(16'd40, 16'd0);
		while (bytes_sent < DIRECTED_N + 136)
			send_random_item();
		drain();

		if (expected_pixels.size() != 0)
			errors++;
		$display("sent %0d bytes (%0d run tags), checked %0d pixels over four geometries",
			bytes_sent, runs_sent, pixels_seen);
		$display("image end %0s, %0d mismatches", image_done ? "reached" : "missed", errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
hdl/qoi_pkg.sv
hdl/qoi_cache.sv
hdl/qoi_decode.sv
hdl/qoi_raster.sv
hdl/qoi_style_rgb_pixel_decoder_top.sv
hdl/qoi_chk.sv
test/tb_qoi_style_rgb_pixel_decoder_top.sv
